// ===== rtl/fnnd_pkg.sv =====
// shared types and constants of the fit-to-window nearest neighbor downscaler
// no dependencies; imported by every module of the block but fnnd_div
`timescale 1ns / 1ps
`default_nettype none

package fnnd_pkg;

	localparam int PIX_W      = 32;
	localparam int COORD_W    = 12;
	localparam int SRC_W_BITS = 12;
	localparam int SRC_H_BITS = 13;
	localparam int WIN_BITS   = 13;
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;
	localparam int QDEPTH     = 4;
	localparam int QAW        = 2;

	typedef enum logic [1:0] {
		REG_SRC_W = 2'd0,
		REG_SRC_H = 2'd1,
		REG_WIN_W = 2'd2,
		REG_WIN_H = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic busy;
		logic acc_load;
	} fit_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/fnnd_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// no package dependencies; used by fnnd_fit
`timescale 1ns / 1ps
`default_nettype none

module fnnd_div #(
	parameter int NW = 26,
	parameter int MW = 13
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [MW-1:0] divisor,
	output logic               done,
	output logic [NW-1:0]      quot,
	output logic [MW-1:0]      rem
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [MW-1:0] rem_q;
	logic [MW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;

	logic [MW:0]   trial;
	logic          fits;
	logic [MW-1:0] rem_n;

	always_comb begin
		trial = {rem_q, num_q[NW-1]};
		fits  = trial >= {1'b0, div_q};
		rem_n = fits ? MW'(trial - {1'b0, div_q}) : trial[MW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(NW);
		end else if (run_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[NW-2:0], fits};
			rem_q <= rem_n;
		end
	end

	assign done = done_q;
	assign quot = num_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/fnnd_fit.sv =====
// register bank and fit sequencer: drawn sizes, step ratios and offsets
// depends on fnnd_pkg and fnnd_div
`timescale 1ns / 1ps
`default_nettype none

module fnnd_fit import fnnd_pkg::*; #(
	parameter int MAX_SW = 2048,
	parameter int MAX_SH = 4096,
	parameter int MAX_WIN = 4096,
	parameter int WS = 12,
	parameter int HS = 13,
	parameter int WW = 13
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready,
	output fit_ctl_t               ctl,
	output logic [WS-1:0]          eff_sw,
	output logic [HS-1:0]          eff_sh,
	output logic [WS-1:0]          dw,
	output logic [HS-1:0]          dh,
	output logic [WS-1:0]          qx,
	output logic [WS-1:0]          rx,
	output logic [HS-1:0]          qy,
	output logic [HS-1:0]          ry,
	output logic [WW-1:0]          off_x,
	output logic [WW-1:0]          off_y,
	input  wire logic [WS-1:0]     dst_col,
	input  wire logic [HS-1:0]     dst_row,
	output logic [WS-1:0]          acc_qc,
	output logic [WS-1:0]          acc_rc,
	output logic [HS-1:0]          acc_qr,
	output logic [HS-1:0]          acc_rr
);

	localparam int MW0 = (WS > HS) ? WS : HS;
	localparam int MW  = (MW0 > WW) ? MW0 : WW;
	localparam int NW  = 2 * MW;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_FIT_H  = 7'b0000010,
		S_FIT_W  = 7'b0000100,
		S_STEP_X = 7'b0001000,
		S_STEP_Y = 7'b0010000,
		S_ACC_X  = 7'b0100000,
		S_ACC_Y  = 7'b1000000
	} seq_state_t;

	seq_state_t state_q;
	logic       run_q;

	logic [SRC_W_BITS-1:0] src_w_q;
	logic [SRC_H_BITS-1:0] src_h_q;
	logic [WIN_BITS-1:0]   win_w_q;
	logic [WIN_BITS-1:0]   win_h_q;

	logic [WS-1:0] w1_q;
	logic [HS-1:0] h1_q;
	logic [WS-1:0] dw_q;
	logic [HS-1:0] dh_q;
	logic [WS-1:0] qx_q;
	logic [WS-1:0] rx_q;
	logic [HS-1:0] qy_q;
	logic [HS-1:0] ry_q;
	logic [WS-1:0] qc_q;
	logic [WS-1:0] rc_q;

	logic [WW-1:0] eff_ww;
	logic [WW-1:0] eff_wh;

	logic          wr_en;
	logic          div_start;
	logic          div_done;
	logic [NW-1:0] div_quot;
	logic [MW-1:0] div_rem;
	logic [MW-1:0] op_a;
	logic [MW-1:0] op_b;
	logic [MW-1:0] op_d;
	logic [NW-1:0] prod;
	logic          ew_big;
	logic          h1_big;
	logic [WS-1:0] w2;
	logic [HS-1:0] h2;
	logic          step_done;

	// saturate sizes to [1, max]
	always_comb begin
		if (src_w_q == '0)
			eff_sw = WS'(1);
		else if (32'(src_w_q) > 32'(MAX_SW))
			eff_sw = WS'(MAX_SW);
		else
			eff_sw = WS'(src_w_q);
		if (src_h_q == '0)
			eff_sh = HS'(1);
		else if (32'(src_h_q) > 32'(MAX_SH))
			eff_sh = HS'(MAX_SH);
		else
			eff_sh = HS'(src_h_q);
		if (win_w_q == '0)
			eff_ww = WW'(1);
		else if (32'(win_w_q) > 32'(MAX_WIN))
			eff_ww = WW'(MAX_WIN);
		else
			eff_ww = WW'(win_w_q);
		if (win_h_q == '0)
			eff_wh = WW'(1);
		else if (32'(win_h_q) > 32'(MAX_WIN))
			eff_wh = WW'(MAX_WIN);
		else
			eff_wh = WW'(win_h_q);
	end

	assign wr_en     = psel & penable & pwrite;
	assign div_start = (state_q != S_IDLE) & ~run_q & ~wr_en;
	assign step_done = run_q & div_done;

	always_comb begin
		op_a = '0;
		op_b = '0;
		op_d = MW'(1);
		unique case (state_q)
			S_IDLE: begin
				op_a = '0;
			end
			S_FIT_H: begin
				op_a = MW'(eff_sh);
				op_b = MW'(eff_ww);
				op_d = MW'(eff_sw);
			end
			S_FIT_W: begin
				op_a = MW'(w1_q);
				op_b = MW'(eff_wh);
				op_d = MW'(h1_q);
			end
			S_STEP_X: begin
				op_a = MW'(eff_sw);
				op_b = MW'(1);
				op_d = MW'(dw_q);
			end
			S_STEP_Y: begin
				op_a = MW'(eff_sh);
				op_b = MW'(1);
				op_d = MW'(dh_q);
			end
			S_ACC_X: begin
				op_a = MW'(dst_col);
				op_b = MW'(eff_sw);
				op_d = MW'(dw_q);
			end
			S_ACC_Y: begin
				op_a = MW'(dst_row);
				op_b = MW'(eff_sh);
				op_d = MW'(dh_q);
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	assign prod = {{MW{1'b0}}, op_a} * {{MW{1'b0}}, op_b};

	fnnd_div #(
		.NW(NW),
		.MW(MW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (op_d),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_comb begin
		ew_big = MW'(eff_sw) > MW'(eff_ww);
		h1_big = MW'(h1_q) > MW'(eff_wh);
		w2     = h1_big ? WS'(div_quot) : w1_q;
		h2     = h1_big ? HS'(eff_wh) : h1_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			run_q   <= 1'b0;
			src_w_q <= SRC_W_BITS'(1);
			src_h_q <= SRC_H_BITS'(1);
			win_w_q <= WIN_BITS'(1);
			win_h_q <= WIN_BITS'(1);
			w1_q    <= WS'(1);
			h1_q    <= HS'(1);
			dw_q    <= WS'(1);
			dh_q    <= HS'(1);
			qx_q    <= WS'(1);
			rx_q    <= '0;
			qy_q    <= HS'(1);
			ry_q    <= '0;
			qc_q    <= '0;
			rc_q    <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_SRC_W: src_w_q <= pwdata[SRC_W_BITS-1:0];
				REG_SRC_H: src_h_q <= pwdata[SRC_H_BITS-1:0];
				REG_WIN_W: win_w_q <= pwdata[WIN_BITS-1:0];
				REG_WIN_H: win_h_q <= pwdata[WIN_BITS-1:0];
				default:   src_w_q <= src_w_q;
			endcase
			state_q <= S_FIT_H;
			run_q   <= 1'b0;
		end else begin
			if (div_start)
				run_q <= 1'b1;
			if (step_done) begin
				run_q <= 1'b0;
				unique case (state_q)
					S_FIT_H: begin
						if (ew_big) begin
							h1_q <= HS'(div_quot);
							w1_q <= WS'(eff_ww);
						end else begin
							h1_q <= eff_sh;
							w1_q <= eff_sw;
						end
						state_q <= S_FIT_W;
					end
					S_FIT_W: begin
						dw_q    <= (w2 == '0) ? WS'(1) : w2;
						dh_q    <= (h2 == '0) ? HS'(1) : h2;
						state_q <= S_STEP_X;
					end
					S_STEP_X: begin
						qx_q    <= WS'(div_quot);
						rx_q    <= WS'(div_rem);
						state_q <= S_STEP_Y;
					end
					S_STEP_Y: begin
						qy_q    <= HS'(div_quot);
						ry_q    <= HS'(div_rem);
						state_q <= S_ACC_X;
					end
					S_ACC_X: begin
						qc_q    <= WS'(div_quot);
						rc_q    <= WS'(div_rem);
						state_q <= S_ACC_Y;
					end
					S_ACC_Y: begin
						state_q <= S_IDLE;
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_SRC_W: prdata = APB_DW'(src_w_q);
			REG_SRC_H: prdata = APB_DW'(src_h_q);
			REG_WIN_W: prdata = APB_DW'(win_w_q);
			REG_WIN_H: prdata = APB_DW'(win_h_q);
			default:   prdata = '0;
		endcase
	end

	assign pready       = 1'b1;
	assign ctl.busy     = (state_q != S_IDLE);
	assign ctl.acc_load = step_done & (state_q == S_ACC_Y) & ~wr_en;
	assign dw           = dw_q;
	assign dh           = dh_q;
	assign qx           = qx_q;
	assign rx           = rx_q;
	assign qy           = qy_q;
	assign ry           = ry_q;
	assign off_x        = (eff_ww - WW'(dw_q)) >> 1;
	assign off_y        = (eff_wh - WW'(dh_q)) >> 1;
	assign acc_qc       = qc_q;
	assign acc_rc       = rc_q;
	assign acc_qr       = HS'(div_quot);
	assign acc_rr       = HS'(div_rem);

	a_drawn_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (dw_q <= eff_sw) && (dh_q <= eff_sh) &&
			(MW'(dw_q) <= MW'(eff_ww)) && (MW'(dh_q) <= MW'(eff_wh)))
		else $error("drawn size exceeds source or window");

	a_drawn_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (dw_q != '0) && (dh_q != '0))
		else $error("drawn size is zero");

endmodule

`default_nettype wire

// ===== rtl/fnnd_front.sv =====
// front end: takes source beats, tracks raster and pick counters, picks pixels
// depends on fnnd_pkg; feeds the result queue in fnnd_back
`timescale 1ns / 1ps
`default_nettype none

module fnnd_front import fnnd_pkg::*; #(
	parameter int WS = 12,
	parameter int HS = 13
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             pix_valid,
	output logic                  pix_stall,
	input  wire logic             frame_start,
	input  wire logic [PIX_W-1:0] source_pixel,
	input  wire fit_ctl_t         ctl,
	input  wire logic             q_full,
	input  wire logic [WS-1:0]    eff_sw,
	input  wire logic [HS-1:0]    eff_sh,
	input  wire logic [WS-1:0]    dw,
	input  wire logic [HS-1:0]    dh,
	input  wire logic [WS-1:0]    qx,
	input  wire logic [WS-1:0]    rx,
	input  wire logic [HS-1:0]    qy,
	input  wire logic [HS-1:0]    ry,
	input  wire logic [WS-1:0]    acc_qc,
	input  wire logic [WS-1:0]    acc_rc,
	input  wire logic [HS-1:0]    acc_qr,
	input  wire logic [HS-1:0]    acc_rr,
	output logic [WS-1:0]         dst_col,
	output logic [HS-1:0]         dst_row,
	output logic                  push,
	output logic [PIX_W-1:0]      push_pixel,
	output logic [WS-1:0]         push_col,
	output logic [HS-1:0]         push_row,
	output logic                  push_last
);

	logic [WS-1:0] src_col_q, dst_col_q, npc_q, qc_q, rc_q;
	logic [HS-1:0] src_row_q, dst_row_q, npr_q, qr_q, rr_q;

	logic [WS-1:0] c_src_col, c_dst_col, c_npc, c_qc, c_rc;
	logic [HS-1:0] c_src_row, c_dst_row, c_npr, c_qr, c_rr;

	logic          accept;
	logic          emit;
	logic [WS:0]   col_inc;
	logic [HS:0]   row_inc;
	logic          col_wrap;
	logic          last;
	logic [WS:0]   sum_rc;
	logic          cx;
	logic [WS-1:0] rc_n;
	logic [WS-1:0] qc_n;
	logic [HS:0]   sum_rr;
	logic          cy;
	logic [HS-1:0] rr_n;
	logic [HS-1:0] qr_n;
	logic [WS:0]   src_col_inc;
	logic          src_wrap;
	logic          src_run;

	assign pix_stall = ctl.busy | q_full;
	assign accept    = pix_valid & ~pix_stall;

	always_comb begin
		c_src_col = frame_start ? '0 : src_col_q;
		c_src_row = frame_start ? '0 : src_row_q;
		c_dst_col = frame_start ? '0 : dst_col_q;
		c_dst_row = frame_start ? '0 : dst_row_q;
		c_npc     = frame_start ? '0 : npc_q;
		c_npr     = frame_start ? '0 : npr_q;
		c_qc      = frame_start ? '0 : qc_q;
		c_rc      = frame_start ? '0 : rc_q;
		c_qr      = frame_start ? '0 : qr_q;
		c_rr      = frame_start ? '0 : rr_q;

		emit = (c_dst_row < dh) && (c_src_row < eff_sh) &&
			(c_src_row == c_npr) && (c_src_col == c_npc);

		col_inc  = {1'b0, c_dst_col} + (WS+1)'(1);
		row_inc  = {1'b0, c_dst_row} + (HS+1)'(1);
		col_wrap = col_inc >= {1'b0, dw};
		last     = (row_inc >= {1'b0, dh}) && col_wrap;

		// running quotient and remainder of dst*src/drawn
		sum_rc = {1'b0, c_rc} + {1'b0, rx};
		cx     = sum_rc >= {1'b0, dw};
		rc_n   = cx ? WS'(sum_rc - {1'b0, dw}) : WS'(sum_rc);
		qc_n   = c_qc + qx + WS'(cx);
		sum_rr = {1'b0, c_rr} + {1'b0, ry};
		cy     = sum_rr >= {1'b0, dh};
		rr_n   = cy ? HS'(sum_rr - {1'b0, dh}) : HS'(sum_rr);
		qr_n   = c_qr + qy + HS'(cy);

		src_col_inc = {1'b0, c_src_col} + (WS+1)'(1);
		src_wrap    = src_col_inc >= {1'b0, eff_sw};
		src_run     = c_src_row < eff_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			dst_col_q <= '0;
			dst_row_q <= '0;
			npc_q     <= '0;
			npr_q     <= '0;
			qc_q      <= '0;
			rc_q      <= '0;
			qr_q      <= '0;
			rr_q      <= '0;
		end else if (ctl.acc_load) begin
			qc_q <= acc_qc;
			rc_q <= acc_rc;
			qr_q <= acc_qr;
			rr_q <= acc_rr;
		end else if (accept) begin
			src_col_q <= c_src_col;
			src_row_q <= c_src_row;
			dst_col_q <= c_dst_col;
			dst_row_q <= c_dst_row;
			npc_q     <= c_npc;
			npr_q     <= c_npr;
			qc_q      <= c_qc;
			rc_q      <= c_rc;
			qr_q      <= c_qr;
			rr_q      <= c_rr;
			if (src_run) begin
				if (src_wrap) begin
					src_col_q <= '0;
					src_row_q <= c_src_row + HS'(1);
				end else begin
					src_col_q <= WS'(src_col_inc);
				end
			end
			if (emit) begin
				if (col_wrap) begin
					dst_col_q <= '0;
					dst_row_q <= HS'(row_inc);
					npc_q     <= '0;
					qc_q      <= '0;
					rc_q      <= '0;
					qr_q      <= qr_n;
					rr_q      <= rr_n;
					npr_q     <= qr_n;
				end else begin
					dst_col_q <= WS'(col_inc);
					qc_q      <= qc_n;
					rc_q      <= rc_n;
					npc_q     <= qc_n;
				end
			end
		end
	end

	assign dst_col    = dst_col_q;
	assign dst_row    = dst_row_q;
	assign push       = accept & emit;
	assign push_pixel = source_pixel;
	assign push_col   = c_dst_col;
	assign push_row   = c_dst_row;
	assign push_last  = last;

	a_rem_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.busy |-> (rc_q < dw) && (rr_q < dh))
		else $error("pick remainder out of range");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.acc_load |-> !push && ctl.busy)
		else $error("pick reload collides with a beat");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (dst_row_q <= dh))
		else $error("output row ran past drawn height");

endmodule

`default_nettype wire

// ===== rtl/fnnd_back.sv =====
// back end: short result queue and window coordinate formatting
// depends on fnnd_pkg; fed by fnnd_front, drives the result channel
`timescale 1ns / 1ps
`default_nettype none

module fnnd_back import fnnd_pkg::*; #(
	parameter int WS = 12,
	parameter int HS = 13,
	parameter int WW = 13
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [PIX_W-1:0] push_pixel,
	input  wire logic [WS-1:0]    push_col,
	input  wire logic [HS-1:0]    push_row,
	input  wire logic             push_last,
	output logic                  full,
	input  wire logic [WW-1:0]    off_x,
	input  wire logic [WW-1:0]    off_y,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [PIX_W-1:0]      out_pixel,
	output logic [COORD_W-1:0]    out_x,
	output logic [COORD_W-1:0]    out_y,
	output logic                  frame_last
);

	localparam int XW0 = ((WW > WS) ? WW : WS) + 1;
	localparam int XW  = (XW0 > COORD_W) ? XW0 : COORD_W;
	localparam int YW0 = ((WW > HS) ? WW : HS) + 1;
	localparam int YW  = (YW0 > COORD_W) ? YW0 : COORD_W;

	logic [PIX_W-1:0] pix_q  [QDEPTH];
	logic [WS-1:0]    col_q  [QDEPTH];
	logic [HS-1:0]    row_q  [QDEPTH];
	logic             last_q [QDEPTH];

	logic [QAW-1:0]   wr_q;
	logic [QAW-1:0]   rd_q;
	logic [QAW:0]     count_q;
	logic             pop;
	logic [XW-1:0]    sum_x;
	logic [YW-1:0]    sum_y;

	assign full      = (count_q == (QAW+1)'(QDEPTH));
	assign out_valid = (count_q != '0);
	assign pop       = out_valid & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QAW'(1);
			if (pop)
				rd_q <= rd_q + QAW'(1);
			if (push && !pop)
				count_q <= count_q + (QAW+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (QAW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			pix_q[wr_q]  <= push_pixel;
			col_q[wr_q]  <= push_col;
			row_q[wr_q]  <= push_row;
			last_q[wr_q] <= push_last;
		end
	end

	// centring offset plus scaled position, wrapped to the coordinate width
	always_comb begin
		sum_x = XW'(off_x) + XW'(col_q[rd_q]);
		sum_y = YW'(off_y) + YW'(row_q[rd_q]);
	end

	assign out_pixel  = pix_q[rd_q];
	assign out_x      = sum_x[COORD_W-1:0];
	assign out_y      = sum_y[COORD_W-1:0];
	assign frame_last = last_q[rd_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("beat pushed into a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW+1)'(QDEPTH))
		else $error("queue count out of range");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + (QAW+1)'(1)))
		else $error("queue count missed a push");

endmodule

`default_nettype wire

// ===== rtl/fit_nearest_neighbour_downscaler.sv =====
// top level of the fit-to-window nearest neighbor downscaler
// depends on fnnd_pkg, fnnd_fit, fnnd_front and fnnd_back
`timescale 1ns / 1ps
`default_nettype none

// Source pixels enter in raster order, one beat per clock unless stalled, and
// each beat yields zero or one result beat with the picked pixel, its centred
// window coordinates and a last-of-frame flag. In steady state the block
// takes one beat per clock; the front end decides each pick with a single add
// and compare on running quotient/remainder pairs, and a four-entry queue in
// front of the result port lets the input keep flowing while a result waits.
// After every register write the fit unit recomputes the drawn sizes, the
// per-pixel step ratios and the pick positions through six passes of one
// bit-serial divider; pix_stall is high until the fit unit is idle again.
// A beat with frame_start high restarts all counters.
module fit_nearest_neighbour_downscaler import fnnd_pkg::*; #(
	parameter int MAX_SOURCE_WIDTH = 2048,
	parameter int MAX_SOURCE_HEIGHT = 4096,
	parameter int MAX_WINDOW_SIZE = 4096
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready,
	input  wire logic              pix_valid,
	output logic                   pix_stall,
	input  wire logic              frame_start,
	input  wire logic [PIX_W-1:0]  source_pixel,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [PIX_W-1:0]       out_pixel,
	output logic [COORD_W-1:0]     out_x,
	output logic [COORD_W-1:0]     out_y,
	output logic                   frame_last
);

	localparam int WS = $clog2(MAX_SOURCE_WIDTH + 1);
	localparam int HS = $clog2(MAX_SOURCE_HEIGHT + 1);
	localparam int WW = $clog2(MAX_WINDOW_SIZE + 1);

	fit_ctl_t         ctl;
	logic [WS-1:0]    eff_sw;
	logic [HS-1:0]    eff_sh;
	logic [WS-1:0]    dw;
	logic [HS-1:0]    dh;
	logic [WS-1:0]    qx;
	logic [WS-1:0]    rx;
	logic [HS-1:0]    qy;
	logic [HS-1:0]    ry;
	logic [WW-1:0]    off_x;
	logic [WW-1:0]    off_y;
	logic [WS-1:0]    dst_col;
	logic [HS-1:0]    dst_row;
	logic [WS-1:0]    acc_qc;
	logic [WS-1:0]    acc_rc;
	logic [HS-1:0]    acc_qr;
	logic [HS-1:0]    acc_rr;
	logic             q_full;
	logic             push;
	logic [PIX_W-1:0] push_pixel;
	logic [WS-1:0]    push_col;
	logic [HS-1:0]    push_row;
	logic             push_last;

	fnnd_fit #(
		.MAX_SW  (MAX_SOURCE_WIDTH),
		.MAX_SH  (MAX_SOURCE_HEIGHT),
		.MAX_WIN (MAX_WINDOW_SIZE),
		.WS      (WS),
		.HS      (HS),
		.WW      (WW)
	) u_fit (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.ctl     (ctl),
		.eff_sw  (eff_sw),
		.eff_sh  (eff_sh),
		.dw      (dw),
		.dh      (dh),
		.qx      (qx),
		.rx      (rx),
		.qy      (qy),
		.ry      (ry),
		.off_x   (off_x),
		.off_y   (off_y),
		.dst_col (dst_col),
		.dst_row (dst_row),
		.acc_qc  (acc_qc),
		.acc_rc  (acc_rc),
		.acc_qr  (acc_qr),
		.acc_rr  (acc_rr)
	);

	fnnd_front #(
		.WS (WS),
		.HS (HS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_valid    (pix_valid),
		.pix_stall    (pix_stall),
		.frame_start  (frame_start),
		.source_pixel (source_pixel),
		.ctl          (ctl),
		.q_full       (q_full),
		.eff_sw       (eff_sw),
		.eff_sh       (eff_sh),
		.dw           (dw),
		.dh           (dh),
		.qx           (qx),
		.rx           (rx),
		.qy           (qy),
		.ry           (ry),
		.acc_qc       (acc_qc),
		.acc_rc       (acc_rc),
		.acc_qr       (acc_qr),
		.acc_rr       (acc_rr),
		.dst_col      (dst_col),
		.dst_row      (dst_row),
		.push         (push),
		.push_pixel   (push_pixel),
		.push_col     (push_col),
		.push_row     (push_row),
		.push_last    (push_last)
	);

	fnnd_back #(
		.WS (WS),
		.HS (HS),
		.WW (WW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_pixel (push_pixel),
		.push_col   (push_col),
		.push_row   (push_row),
		.push_last  (push_last),
		.full       (q_full),
		.off_x      (off_x),
		.off_y      (off_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_pixel  (out_pixel),
		.out_x      (out_x),
		.out_y      (out_y),
		.frame_last (frame_last)
	);

endmodule

`default_nettype wire

// ===== sim/fit_nearest_neighbour_downscaler_test.sv =====
// self-checking testbench of the fit-to-window nearest neighbor downscaler
// depends on fnnd_pkg and fit_nearest_neighbour_downscaler; predicts each picked pixel
// from its own copy of the fit sizes and pick counters and checks every result beat
`timescale 1ns / 1ps

module fit_nearest_neighbour_downscaler_test;

	import fnnd_pkg::*;

	localparam int unsigned MAX_SW  = 2048;
	localparam int unsigned MAX_SH  = 4096;
	localparam int unsigned MAX_WIN = 4096;
	localparam int          ITEMS   = 1750;

	typedef struct packed {
		logic             fs;
		logic [PIX_W-1:0] pix;
	} src_beat_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               last;
	} pick_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              pix_valid = 1'b0;
	logic              pix_stall;
	logic              frame_start = 1'b0;
	logic [PIX_W-1:0]  source_pixel = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [PIX_W-1:0]  out_pixel;
	logic [COORD_W-1:0] out_x;
	logic [COORD_W-1:0] out_y;
	logic              frame_last;

	logic calm = 1'b0;
	logic hold_go = 1'b0;
	logic hold_off = 1'b0;

	src_beat_t source_q[$];
	pick_t     picked_q[$];
	src_beat_t drv_beat;
	pick_t     want;
	int        fed_count = 0;
	int        mismatches = 0;

	// predictor copy of registers and counters
	int unsigned reg_sw = 1, reg_sh = 1, reg_ww = 1, reg_wh = 1;
	int unsigned fit_w = 1, fit_h = 1;
	int unsigned col_in = 0, row_in = 0, col_out = 0, row_out = 0;
	int unsigned want_col = 0, want_row = 0;

	fit_nearest_neighbour_downscaler u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.pix_valid    (pix_valid),
		.pix_stall    (pix_stall),
		.frame_start  (frame_start),
		.source_pixel (source_pixel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_pixel    (out_pixel),
		.out_x        (out_x),
		.out_y        (out_y),
		.frame_last   (frame_last)
	);

	always #6 clk = ~clk;

	function automatic int unsigned sat_size(input int unsigned v, input int unsigned max_v);
		if (v < 1) return 1;
		if (v > max_v) return max_v;
		return v;
	endfunction

	function automatic void pick_step(input logic fs, input logic [PIX_W-1:0] pix);
		int unsigned sw, sh, offx, offy;
		pick_t p;
		sw = sat_size(reg_sw, MAX_SW);
		sh = sat_size(reg_sh, MAX_SH);
		if (fs) begin
			col_in = 0;
			row_in = 0;
			col_out = 0;
			row_out = 0;
			want_col = 0;
			want_row = 0;
		end
		if (row_out < fit_h && row_in < sh && row_in == want_row && col_in == want_col) begin
			offx = (sat_size(reg_ww, MAX_WIN) - fit_w) / 2;
			offy = (sat_size(reg_wh, MAX_WIN) - fit_h) / 2;
			p.pixel = pix;
			p.x = COORD_W'(offx + col_out);
			p.y = COORD_W'(offy + row_out);
			p.last = (row_out + 1 >= fit_h) && (col_out + 1 >= fit_w);
			picked_q.push_back(p);
			col_out++;
			if (col_out >= fit_w) begin
				col_out = 0;
				row_out++;
				want_col = 0;
				want_row = row_out * sh / fit_h;
			end else begin
				want_col = col_out * sw / fit_w;
			end
		end
		if (row_in < sh) begin
			col_in++;
			if (col_in >= sw) begin
				col_in = 0;
				row_in++;
			end
		end
	endfunction

	function automatic void queue_beat(input logic fs, input logic [PIX_W-1:0] pix);
		src_beat_t b;
		b.fs = fs;
		b.pix = pix;
		source_q.push_back(b);
		fed_count++;
	endfunction

	task automatic reg_write(input reg_idx_t idx, input int unsigned value);
		int unsigned w, h, ww, wh;
		repeat (200) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SRC_W: reg_sw = value & 32'hFFF;
			REG_SRC_H: reg_sh = value & 32'h1FFF;
			REG_WIN_W: reg_ww = value & 32'h1FFF;
			REG_WIN_H: reg_wh = value & 32'h1FFF;
			default: ;
		endcase
		w = sat_size(reg_sw, MAX_SW);
		h = sat_size(reg_sh, MAX_SH);
		ww = sat_size(reg_ww, MAX_WIN);
		wh = sat_size(reg_wh, MAX_WIN);
		if (w > ww) begin
			h = h * ww / w;
			w = ww;
		end
		if (h > wh) begin
			w = w * wh / h;
			h = wh;
		end
		if (w < 1) w = 1;
		if (h < 1) h = 1;
		fit_w = w;
		fit_h = h;
	endtask

	task automatic set_fit_registers(input int unsigned sw, input int unsigned sh,
			input int unsigned ww, input int unsigned wh);
		reg_write(REG_SRC_W, sw);
		reg_write(REG_SRC_H, sh);
		reg_write(REG_WIN_W, ww);
		reg_write(REG_WIN_H, wh);
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (source_q.size() != 0 || pix_valid || picked_q.size() != 0);
		repeat (64) @(posedge clk);
	endtask

	// frames in raster order; noisy frames may be cut short, overrun, restart or lack a start
	task automatic queue_frames(input int nframes, input int unsigned cap, input bit noisy);
		int unsigned len, kind, extra, k;
		int f;
		logic fs;
		for (f = 0; f < nframes; f++) begin
			kind = noisy ? $urandom_range(9) : 9;
			len = sat_size(reg_sw, MAX_SW) * sat_size(reg_sh, MAX_SH);
			if (len > cap) len = cap;
			if (kind == 0) len = $urandom_range(1, len);
			extra = (kind == 1) ? $urandom_range(1, 6) : 0;
			for (k = 0; k < len + extra; k++) begin
				fs = (k == 0 && kind != 3) || (kind == 2 && $urandom_range(15) == 0);
				queue_beat(fs, $urandom());
			end
		end
	endtask

	always @(posedge clk) begin
		if (pix_valid && !pix_stall) pick_step(frame_start, source_pixel);
		if (!pix_valid || !pix_stall) begin
			if (source_q.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
				drv_beat = source_q.pop_front();
				pix_valid <= 1'b1;
				frame_start <= drv_beat.fs;
				source_pixel <= drv_beat.pix;
			end else begin
				pix_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (picked_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result beat: pixel %h x %0d y %0d last %b",
							out_pixel, out_x, out_y, frame_last);
					mismatches++;
				end else begin
					want = picked_q.pop_front();
					if (out_pixel !== want.pixel || out_x !== want.x || out_y !== want.y ||
							frame_last !== want.last) begin
						if (mismatches < 10)
							$display("mismatch: expected pixel %h x %0d y %0d last %b, got pixel %h x %0d y %0d last %b",
								want.pixel, want.x, want.y, want.last,
								out_pixel, out_x, out_y, frame_last);
						mismatches++;
					end
				end
			end
			out_stall <= hold_off || (!calm && $urandom_range(99) < 31);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// long receiver hold-off so the block fills up and stalls its input
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("fit_nearest_neighbour_downscaler test failed");
		$finish;
	end

	initial begin
		int unsigned sw, sh, ww, wh, r, cap;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset, no frame start on the first beat
		queue_beat(1'b0, 32'h0000_0000);
		queue_beat(1'b0, 32'hFFFF_FFFF);
		queue_beat(1'b1, 32'hFFFF_FFFF);
		queue_beat(1'b0, 32'h0000_0000);
		wait_idle();

		// zero sizes act as one
		set_fit_registers(0, 0, 0, 0);
		queue_beat(1'b1, 32'h1234_5678);
		wait_idle();

		// no downscale, centered, with beats past the frame
		set_fit_registers(4, 3, 16, 16);
		queue_frames(1, 300, 1'b0);
		queue_beat(1'b0, $urandom());
		wait_idle();

		// width cut first, then height cut
		set_fit_registers(4, 2, 2, 4);
		queue_frames(1, 300, 1'b0);
		wait_idle();
		set_fit_registers(2, 4, 4, 2);
		queue_frames(1, 300, 1'b0);
		wait_idle();

		// saturated and extreme sizes, partial frames
		set_fit_registers(4095, 8191, 8191, 8191);
		queue_frames(2, 40, 1'b0);
		wait_idle();
		set_fit_registers(2048, 4096, 1, 1);
		queue_frames(2, 20, 1'b0);
		wait_idle();
		set_fit_registers(1, 4096, 4096, 1);
		queue_frames(1, 10, 1'b0);
		wait_idle();

		// back pressure with a steady sender
		set_fit_registers(5, 5, 8, 8);
		calm <= 1'b1;
		hold_go <= 1'b1;
		queue_frames(24, 300, 1'b1);
		wait_idle();
		calm <= 1'b0;

		while (fed_count < ITEMS) begin
			r = $urandom_range(9);
			sw = $urandom_range(0, 12);
			sh = $urandom_range(0, 12);
			ww = $urandom_range(0, 16);
			wh = $urandom_range(0, 16);
			cap = 300;
			if (r == 0) ww = $urandom_range(0, 8191);
			if (r == 1) wh = $urandom_range(0, 8191);
			if (r == 2) begin
				sw = $urandom_range(0, 4095);
				cap = 60;
			end
			if (r == 3) begin
				sh = $urandom_range(0, 8191);
				cap = 60;
			end
			set_fit_registers(sw, sh, ww, wh);
			queue_frames($urandom_range(2, 6), cap, 1'b1);
			wait_idle();
		end

		if (mismatches == 0) begin
			$display("fit_nearest_neighbour_downscaler test passed");
		end else begin
			$display("fit_nearest_neighbour_downscaler test failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/fnnd_pkg.sv
rtl/fnnd_div.sv
rtl/fnnd_fit.sv
rtl/fnnd_front.sv
rtl/fnnd_back.sv
rtl/fit_nearest_neighbour_downscaler.sv
sim/fit_nearest_neighbour_downscaler_test.sv
